// ===== design/mi3_pkg.sv =====
`default_nettype none

package mi3_pkg;

  localparam int ELEMENT_WIDTH = 16;
  localparam int EW = ELEMENT_WIDTH;
  localparam int FRAC_IN = EW / 2;
  localparam int INV_SHIFT = FRAC_IN + 16;

  localparam int PW = 2 * EW;
  localparam int CW = 2 * EW + 1;
  localparam int CMW = 2 * EW;
  localparam int DPW = EW + CW;
  localparam int DW = 3 * EW + 3;
  localparam int DMW = DW;
  localparam int NW = CMW + INV_SHIFT;

  localparam int OW = 48;
  localparam int DOW = 49;
  localparam int QXW = ((NW > OW) ? NW : OW) + 1;

  localparam int FRONT_LAT = 5;
  localparam int LAT = FRONT_LAT + NW + 1;

  localparam logic [QXW-1:0] INV_MAX = (QXW'(1) << (OW - 1)) - QXW'(1);
  localparam logic [QXW-1:0] INV_MIN_MAG = QXW'(1) << (OW - 1);

  // operand indexes a, b, c, d of each cofactor a*b - c*d, in row-major order of the adjugate
  localparam int CF_IDX [9][4] = '{
    '{4, 8, 7, 5},
    '{2, 7, 8, 1},
    '{1, 5, 4, 2},
    '{5, 6, 8, 3},
    '{0, 8, 6, 2},
    '{2, 3, 5, 0},
    '{3, 7, 6, 4},
    '{1, 6, 7, 0},
    '{0, 4, 3, 1}
  };

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [CW-1:0] cofv_t;
  typedef logic signed [DPW-1:0] dprod_t;
  typedef logic signed [DW-1:0] detv_t;
  typedef logic signed [OW-1:0] inv_t;

  typedef struct packed {
    logic [CMW-1:0] mag;
    logic           neg;
  } cof_t;

  typedef struct packed {
    logic [DMW-1:0] dmag;
    logic           nz;
    logic [DOW-1:0] lo;
  } det_t;

endpackage

`default_nettype wire

// ===== design/mi3_in_if.sv =====
`default_nettype none

interface mi3_in_if;
  import mi3_pkg::*;

  logic  valid;
  logic  ready;
  elem_t m00;
  elem_t m01;
  elem_t m02;
  elem_t m10;
  elem_t m11;
  elem_t m12;
  elem_t m20;
  elem_t m21;
  elem_t m22;

  modport source (
    output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    input  ready
  );

  modport sink (
    input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/mi3_out_if.sv =====
`default_nettype none

interface mi3_out_if;
  import mi3_pkg::*;

  logic                  valid;
  logic                  ready;
  inv_t                  inv_00;
  inv_t                  inv_01;
  inv_t                  inv_02;
  inv_t                  inv_10;
  inv_t                  inv_11;
  inv_t                  inv_12;
  inv_t                  inv_20;
  inv_t                  inv_21;
  inv_t                  inv_22;
  logic signed [DOW-1:0] determinant;
  logic                  invertible;

  modport source (
    output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20, inv_21, inv_22,
    output determinant, invertible,
    input  ready
  );

  modport sink (
    input  valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20, inv_21, inv_22,
    input  determinant, invertible,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/mi3_front.sv =====
`default_nettype none

module mi3_front (
  input  logic           clk,
  input  logic           en,
  input  mi3_pkg::elem_t elem [9],
  output mi3_pkg::cof_t  cof [9],
  output mi3_pkg::det_t  det
);
  import mi3_pkg::*;

  prod_t  pl_r [9];
  prod_t  pr_r [9];
  elem_t  row_s1_r [3];
  elem_t  row_s2_r [3];
  cofv_t  cf_s2_r [9];
  cofv_t  cf_s3_r [9];
  cofv_t  cf_s4_r [9];
  dprod_t dp_r [3];
  detv_t  det_r;
  cof_t   cof_r [9];
  det_t   dt_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // cofactor products
      for (int i = 0; i < 9; i++) begin
        pl_r[i] <= elem[CF_IDX[i][0]] * elem[CF_IDX[i][1]];
        pr_r[i] <= elem[CF_IDX[i][2]] * elem[CF_IDX[i][3]];
      end
      for (int k = 0; k < 3; k++) begin
        row_s1_r[k] <= elem[k];
        row_s2_r[k] <= row_s1_r[k];
      end
      // cofactor differences
      for (int i = 0; i < 9; i++) begin
        cf_s2_r[i] <= CW'(pl_r[i]) - CW'(pr_r[i]);
        cf_s3_r[i] <= cf_s2_r[i];
        cf_s4_r[i] <= cf_s3_r[i];
      end
      // expansion along row 0
      for (int k = 0; k < 3; k++) begin
        dp_r[k] <= row_s2_r[k] * cf_s2_r[3 * k];
      end
      det_r <= DW'(dp_r[0]) + DW'(dp_r[1]) + DW'(dp_r[2]);
      // magnitudes and signs
      dt_r.nz   <= (det_r != '0);
      dt_r.dmag <= det_r[DW-1] ? DMW'(-det_r) : DMW'(det_r);
      dt_r.lo   <= DOW'(det_r);
      for (int i = 0; i < 9; i++) begin
        cof_r[i].mag <= cf_s4_r[i][CW-1] ? CMW'(-cf_s4_r[i]) : CMW'(cf_s4_r[i]);
        cof_r[i].neg <= cf_s4_r[i][CW-1] ^ det_r[DW-1];
      end
    end
  end

  assign cof = cof_r;
  assign det = dt_r;

endmodule

`default_nettype wire

// ===== design/mi3_div.sv =====
`default_nettype none

module mi3_div (
  input  logic                      clk,
  input  logic                      en,
  input  mi3_pkg::cof_t             cof,
  input  logic [mi3_pkg::DMW-1:0]   dmag,
  input  logic                      nz,
  output mi3_pkg::inv_t             inv
);
  import mi3_pkg::*;

  logic [DMW-1:0] rem_w [NW+1];
  logic [NW-1:0]  num_w [NW+1];
  logic [NW-1:0]  quo_w [NW+1];
  logic [DMW-1:0] den_w [NW+1];
  logic           sgn_w [NW+1];
  logic           nz_w  [NW+1];

  logic [QXW-1:0] qx;
  logic           qneg;
  inv_t           inv_nxt;
  inv_t           inv_r;

  assign rem_w[0] = '0;
  assign num_w[0] = {cof.mag, {INV_SHIFT{1'b0}}};
  assign quo_w[0] = '0;
  assign den_w[0] = dmag;
  assign sgn_w[0] = cof.neg;
  assign nz_w[0]  = nz;

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [DMW:0]   trial;
    logic [DMW:0]   diff;
    logic           ge;
    logic [DMW-1:0] rem_nxt;
    logic [DMW-1:0] rem_r;
    logic [NW-1:0]  num_r;
    logic [NW-1:0]  quo_nxt;
    logic [NW-1:0]  quo_r;
    logic [DMW-1:0] den_r;
    logic           sgn_r;
    logic           nz_r;

    always_comb begin
      trial   = {rem_w[s], num_w[s][NW-1]};
      diff    = trial - {1'b0, den_w[s]};
      ge      = ~diff[DMW];
      rem_nxt = ge ? diff[DMW-1:0] : trial[DMW-1:0];
      quo_nxt = {quo_w[s][NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rem_nxt;
        num_r <= num_w[s] << 1;
        quo_r <= quo_nxt;
        den_r <= den_w[s];
        sgn_r <= sgn_w[s];
        nz_r  <= nz_w[s];
      end
    end

    assign rem_w[s+1] = rem_r;
    assign num_w[s+1] = num_r;
    assign quo_w[s+1] = quo_r;
    assign den_w[s+1] = den_r;
    assign sgn_w[s+1] = sgn_r;
    assign nz_w[s+1]  = nz_r;
  end

  // sign and saturation
  always_comb begin
    qx   = QXW'(quo_w[NW]);
    qneg = sgn_w[NW] && (qx != '0);
    if (!nz_w[NW]) begin
      inv_nxt = '0;
    end else if (qneg) begin
      inv_nxt = (qx > INV_MIN_MAG) ? OW'(INV_MIN_MAG) : OW'(QXW'(0) - qx);
    end else begin
      inv_nxt = (qx > INV_MAX) ? OW'(INV_MAX) : OW'(qx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv_r <= inv_nxt;
    end
  end

  assign inv = inv_r;

endmodule

`default_nettype wire

// ===== design/matrix3x3_inverse_unit.sv =====
// 3x3 matrix inverse by the adjugate, fully pipelined
// in_ch: one transaction carries a 3x3 matrix of signed q8.8 elements
// out_ch: one transaction per input matrix, in input order, carrying the
//   nine inverse elements (signed q31.16, saturated), the exact q24.24
//   determinant and the invertible flag; a singular matrix gives all-zero
//   inverse elements and a clear flag
// the pipeline registers cofactor products, cofactor differences, determinant
//   products, the determinant sum, magnitudes and signs, then the 56-bit
//   restoring divider and a final register for sign and saturation
// throughput: one matrix per cycle while the output is not stalled; the nine
//   dividers are pipelined with one subtract stage per quotient bit
// reset: clears the valid bits of every stage; no data is held over
// stall: while the output holds a transaction that is not taken, the whole
//   pipeline holds, in_ch.ready drops, and bubbles waiting in the pipeline
//   are not squeezed out
`default_nettype none

module matrix3x3_inverse_unit (
  input  logic        clk,
  input  logic        rst_n,
  mi3_in_if.sink      in_ch,
  mi3_out_if.source   out_ch
);
  import mi3_pkg::*;

  logic           en;
  logic [LAT-1:0] vld_r;
  elem_t          elem [9];
  cof_t           cof [9];
  det_t           det;
  inv_t           inv [9];
  logic [DOW-1:0] dly_det_r [NW+1];
  logic           dly_nz_r [NW+1];

  assign en          = ~vld_r[LAT-1] | out_ch.ready;
  assign in_ch.ready = en;

  assign elem[0] = in_ch.m00;
  assign elem[1] = in_ch.m01;
  assign elem[2] = in_ch.m02;
  assign elem[3] = in_ch.m10;
  assign elem[4] = in_ch.m11;
  assign elem[5] = in_ch.m12;
  assign elem[6] = in_ch.m20;
  assign elem[7] = in_ch.m21;
  assign elem[8] = in_ch.m22;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  mi3_front u_front (
    .clk  (clk),
    .en   (en),
    .elem (elem),
    .cof  (cof),
    .det  (det)
  );

  for (genvar i = 0; i < 9; i++) begin : g_div
    mi3_div u_div (
      .clk  (clk),
      .en   (en),
      .cof  (cof[i]),
      .dmag (det.dmag),
      .nz   (det.nz),
      .inv  (inv[i])
    );
  end

  // determinant and flag travel alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      dly_det_r[0] <= det.lo;
      dly_nz_r[0]  <= det.nz;
      for (int k = 1; k < NW + 1; k++) begin
        dly_det_r[k] <= dly_det_r[k-1];
        dly_nz_r[k]  <= dly_nz_r[k-1];
      end
    end
  end

  assign out_ch.valid       = vld_r[LAT-1];
  assign out_ch.inv_00      = inv[0];
  assign out_ch.inv_01      = inv[1];
  assign out_ch.inv_02      = inv[2];
  assign out_ch.inv_10      = inv[3];
  assign out_ch.inv_11      = inv[4];
  assign out_ch.inv_12      = inv[5];
  assign out_ch.inv_20      = inv[6];
  assign out_ch.inv_21      = inv[7];
  assign out_ch.inv_22      = inv[8];
  assign out_ch.determinant = dly_det_r[NW];
  assign out_ch.invertible  = dly_nz_r[NW];

endmodule

`default_nettype wire

// ===== tb/sv/matrix3x3_inverse_unit_test.sv =====
`timescale 1ns / 100ps

module matrix3x3_inverse_unit_test;
  import mi3_pkg::*;

  typedef struct {
    logic signed [47:0] inv [9];
    logic [48:0]        det;
    logic               nz;
  } inverse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   busy_ends = 1'b0;
  bit   hold_off = 1'b0;
  int   errors = 0;
  int   no_gaps = 0;
  inverse_t expected_q [$];

  mi3_in_if  in_ch ();
  mi3_out_if out_ch ();

  matrix3x3_inverse_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  function automatic inverse_t predict_inverse(input elem_t e [9]);
    inverse_t res;
    logic signed [63:0] a [9];
    logic signed [63:0] cof [9];
    logic signed [127:0] det, dmag, num, q, qmax;
    int ix [9][4];
    ix = '{'{4, 8, 7, 5}, '{2, 7, 8, 1}, '{1, 5, 4, 2}, '{5, 6, 8, 3}, '{0, 8, 6, 2},
           '{2, 3, 5, 0}, '{3, 7, 6, 4}, '{1, 6, 7, 0}, '{0, 4, 3, 1}};
    qmax = (128'sd1 <<< 47) - 1;
    for (int i = 0; i < 9; i++) a[i] = e[i];
    for (int i = 0; i < 9; i++)
      cof[i] = a[ix[i][0]] * a[ix[i][1]] - a[ix[i][2]] * a[ix[i][3]];
    det = 128'(a[0]) * cof[0] + 128'(a[1]) * cof[3] + 128'(a[2]) * cof[6];
    res.nz = (det != 0);
    res.det = det[48:0];
    dmag = det < 0 ? -det : det;
    for (int i = 0; i < 9; i++) begin
      res.inv[i] = '0;
      if (res.nz) begin
        num = (cof[i] < 0 ? -128'(cof[i]) : 128'(cof[i])) <<< INV_SHIFT;
        q = num / dmag;
        if ((cof[i] < 0) != (det < 0) && q != 0) begin
          res.inv[i] = q > qmax + 1 ? -(qmax + 1) : -q;
        end else begin
          res.inv[i] = q > qmax ? qmax : q;
        end
      end
    end
    return res;
  endfunction

  task automatic send_matrix(input elem_t e [9]);
    while (no_gaps == 0 && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11,
     in_ch.m12, in_ch.m20, in_ch.m21, in_ch.m22} <= {e[0], e[1], e[2], e[3], e[4],
                                                      e[5], e[6], e[7], e[8]};
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_inverse(e));
  endtask

  task automatic send_random(input int n, input int mode);
    elem_t e [9];
    int r;
    repeat (n) begin
      for (int i = 0; i < 9; i++) begin
        r = $urandom_range(9);
        if (mode == 1) e[i] = $signed(16'($urandom_range(15))) - 8;
        else if (r < 2) e[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        else e[i] = 16'($urandom);
      end
      if (mode == 0 && $urandom_range(5) == 0) begin
        r = $urandom_range(2);
        for (int k = 0; k < 3; k++) e[3 * ((r + 1) % 3) + k] = e[3 * r + k];
      end
      send_matrix(e);
    end
  endtask

  task automatic test_directed();
    elem_t e [9];
    e = '{16'sh100, 0, 0, 0, 16'sh100, 0, 0, 0, 16'sh100}; send_matrix(e);
    e = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(e);
    e = '{16'sh7fff, 0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff}; send_matrix(e);
    e = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000}; send_matrix(e);
    e = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh8000, 16'sh7fff, 16'sh7fff}; send_matrix(e);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(e);
    e = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; send_matrix(e);
    e = '{1, 2, 3, 4, 5, 6, 7, 8, 9}; send_matrix(e);
    e = '{16'sh100, 16'sh200, 0, 0, 16'sh100, 0, 16'sh300, 0, -16'sh100}; send_matrix(e);
    e = '{0, 1, 0, 1, 0, 0, 0, 0, -1}; send_matrix(e);
    e = '{16'sh8000, 16'sh8000, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 0, 16'sh8000};
    send_matrix(e);
    e = '{16'sh7fff, 1, 0, 16'sh7fff, 2, 0, 0, 0, 1}; send_matrix(e);
  endtask

  task automatic test_random_gaps();
    send_random(600, 0);
    send_random(200, 1);
  endtask

  task automatic test_full_rate();
    no_gaps = 1;
    send_random(200, 0);
    no_gaps = 0;
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    send_random(250, 0);
    hold_off = 1'b0;
  endtask

  always @(posedge clk) begin
    inverse_t want;
    logic bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction");
      end else begin
        want = expected_q.pop_front();
        bad = out_ch.determinant !== want.det || out_ch.invertible !== want.nz;
        bad |= {out_ch.inv_00, out_ch.inv_01, out_ch.inv_02, out_ch.inv_10, out_ch.inv_11,
                out_ch.inv_12, out_ch.inv_20, out_ch.inv_21, out_ch.inv_22} !==
               {want.inv[0], want.inv[1], want.inv[2], want.inv[3], want.inv[4],
                want.inv[5], want.inv[6], want.inv[7], want.inv[8]};
        if (bad) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp inv %p det %h nz %b, got %h %h %h %h %h %h %h %h %h det %h nz %b",
                     want.inv, want.det, want.nz, out_ch.inv_00, out_ch.inv_01, out_ch.inv_02,
                     out_ch.inv_10, out_ch.inv_11, out_ch.inv_12, out_ch.inv_20,
                     out_ch.inv_21, out_ch.inv_22, out_ch.determinant, out_ch.invertible);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off, no stalls in full-rate phase
  initial begin
    int held;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && held == 0) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < 300; held++) @(posedge clk);
      end
      out_ch.ready <= (no_gaps != 0 || busy_ends) ? 1'b1 : ($urandom_range(99) >= 28);
    end
  end

  initial begin
    int waited;
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11,
     in_ch.m12, in_ch.m20, in_ch.m21, in_ch.m22} = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_gaps();
    test_full_rate();
    test_backpressure();
    in_ch.valid <= 1'b0;
    busy_ends = 1'b1;
    waited = 0;
    while (expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
